// ===== rtl/fertigation_dose_sequencer_unit_macros.svh =====
// Assertion macros shared by the dose sequencer RTL.
`ifndef FERTIGATION_DOSE_SEQUENCER_UNIT_MACROS_SVH
`define FERTIGATION_DOSE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fds check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fds check failed");

`endif

// ===== rtl/fds_pkg.sv =====
// Types and constants of the fertigation dose sequencer.
package fds_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FILL   = 3'd1,
    PH_PHDOSE = 3'd2,
    PH_ECDOSE = 3'd3,
    PH_IRR    = 3'd4,
    PH_FLUSH  = 3'd5,
    PH_ERROR  = 3'd6
  } fds_phase_e;

  typedef enum logic [2:0] {
    CFG_RUN_MODE      = 3'd0,
    CFG_PH_TARGET     = 3'd1,
    CFG_PH_BAND       = 3'd2,
    CFG_EC_TARGET     = 3'd3,
    CFG_EC_BAND       = 3'd4,
    CFG_FLUSH_SECONDS = 3'd5,
    CFG_DOSE_PULSE_MS = 3'd6
  } fds_cfg_idx_e;

  // Relay bit positions.
  localparam int unsigned RLY_WATER   = 0;
  localparam int unsigned RLY_STIRRER = 1;
  localparam int unsigned RLY_BASE    = 2;
  localparam int unsigned RLY_FERT    = 3;
  localparam int unsigned RLY_FLUSH   = 4;
  localparam int unsigned RLY_ALARM   = 5;
  localparam int unsigned NUM_RELAYS  = 6;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned FLUSH_MS_W = 22;

  localparam logic [FLUSH_MS_W-1:0] MS_PER_S = 22'd1000;

  // Register reset values.
  localparam logic        RST_RUN_MODE  = 1'b0;
  localparam logic [10:0] RST_PH_TARGET = 11'd650;
  localparam logic [10:0] RST_PH_BAND   = 11'd50;
  localparam logic [13:0] RST_EC_TARGET = 14'd1500;
  localparam logic [13:0] RST_EC_BAND   = 14'd200;
  localparam logic [11:0] RST_FLUSH_S   = 12'd30;
  localparam logic [19:0] RST_PULSE_MS  = 20'd2000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [10:0] ph_reading;
    logic [13:0] ec_reading;
    logic        ph_ok;
    logic        ec_ok;
  } fds_in_t;

  typedef struct packed {
    logic       water_on;
    logic       stirrer_on;
    logic       base_on;
    logic       fert_on;
    logic       flush_on;
    logic       alarm_on;
    logic [2:0] cur_phase;
    logic       dosing;
  } fds_out_t;

endpackage

// ===== rtl/fertigation_dose_sequencer_unit.sv =====
// Top level of the fertigation dose sequencer: phase control, relays and dose pulses.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (fds_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (fds_out_t)
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One tick transaction a cycle while the result side does not stall; a tick
// passes the input register, then one pass of compare logic into the result
// register, which also updates the sequencer state. Reset puts every
// configuration register at its default and the sequencer at idle with all
// relays off. A stalled result holds in the output register while one further
// tick waits in the input register; further input then stalls.
module fertigation_dose_sequencer_unit #(
  parameter int unsigned FILL_LIMIT_MS = 30000,
  parameter int unsigned FILL_DONE_MS  = 15000,
  parameter int unsigned IRRIGATE_MS   = 60000,
  parameter bit          SIM_BUILD     = 1'b0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fds_pkg::fds_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fds_pkg::fds_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic        run_mode_q;
  logic [10:0] ph_target_q, ph_band_q;
  logic [13:0] ec_target_q, ec_band_q;
  logic [11:0] flush_s_q;
  logic [19:0] pulse_ms_q;

  // Input register and result register.
  logic              in_valid_q;
  fds_pkg::fds_in_t  in_q;
  logic              out_valid_q;
  fds_pkg::fds_out_t out_q;
  fds_pkg::fds_out_t out_d;

  // Sequencer state.
  fds_pkg::fds_phase_e                 phase_q, phase_d;
  logic [31:0]                         start_q, start_d;
  logic [31:0]                         last_dose_q, last_dose_d;
  logic                                dose_q, dose_d;
  logic                                pump_sel_q, pump_sel_d;
  logic [fds_pkg::NUM_RELAYS-1:0]      relays_q, relays_d;

  logic fire;
  logic run_tick;
  logic manual_write;

  // Decode of the tick under work.
  logic                        err_trip;
  fds_pkg::fds_phase_e         cur_phase;
  logic [31:0]                 start_eff;
  logic [31:0]                 elapsed;
  logic [31:0]                 since_dose;
  logic [31:0]                 pulse_32;
  logic [fds_pkg::FLUSH_MS_W-1:0] flush_ms;
  logic                        fill_limit, fill_done, irr_done, flush_done;
  logic                        dose_ready, pulse_over;
  logic [11:0]                 ph_sum, ph_hi;
  logic [14:0]                 ec_sum, ec_hi;
  logic                        ph_low, ph_high, ph_in;
  logic                        ec_low, ec_high, ec_in;

  // Advance the work stage when the result register is free or being drained.
  assign fire         = in_valid_q && (!out_valid_q || out_ready_i);
  assign run_tick     = fire && !run_mode_q;
  assign in_ready_o   = !in_valid_q || fire;
  assign manual_write = cfg_we_i && (cfg_idx_i == fds_pkg::CFG_RUN_MODE) && cfg_data_i[0];

  // ---------------------------------------------------------------------------
  // Configuration port: index beyond the list is dropped by the default arm.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= fds_pkg::RST_RUN_MODE;
      ph_target_q <= fds_pkg::RST_PH_TARGET;
      ph_band_q   <= fds_pkg::RST_PH_BAND;
      ec_target_q <= fds_pkg::RST_EC_TARGET;
      ec_band_q   <= fds_pkg::RST_EC_BAND;
      flush_s_q   <= fds_pkg::RST_FLUSH_S;
      pulse_ms_q  <= fds_pkg::RST_PULSE_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fds_pkg::CFG_RUN_MODE:      run_mode_q  <= cfg_data_i[0];
        fds_pkg::CFG_PH_TARGET:     ph_target_q <= cfg_data_i[10:0];
        fds_pkg::CFG_PH_BAND:       ph_band_q   <= cfg_data_i[10:0];
        fds_pkg::CFG_EC_TARGET:     ec_target_q <= cfg_data_i[13:0];
        fds_pkg::CFG_EC_BAND:       ec_band_q   <= cfg_data_i[13:0];
        fds_pkg::CFG_FLUSH_SECONDS: flush_s_q   <= cfg_data_i[11:0];
        fds_pkg::CFG_DOSE_PULSE_MS: pulse_ms_q  <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: take a tick when empty or when the held one moves on.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared decode. Unless SIM_BUILD is set, an invalid sensor forces the error
  // phase before dispatch; the phase start time only moves on first entry into error.
  // ---------------------------------------------------------------------------
  assign err_trip  = !(in_q.ph_ok && in_q.ec_ok) && !SIM_BUILD;
  assign cur_phase = err_trip ? fds_pkg::PH_ERROR : phase_q;
  assign start_eff = (err_trip && (phase_q != fds_pkg::PH_ERROR)) ? in_q.now_ms : start_q;

  // Time differences wrap modulo 2^32.
  assign elapsed    = in_q.now_ms - start_eff;
  assign since_dose = in_q.now_ms - last_dose_q;
  assign pulse_32   = {12'd0, pulse_ms_q};
  assign flush_ms   = fds_pkg::FLUSH_MS_W'(flush_s_q) * fds_pkg::MS_PER_S;

  assign fill_limit = elapsed > 32'(FILL_LIMIT_MS);
  assign fill_done  = elapsed > 32'(FILL_DONE_MS);
  assign irr_done   = elapsed > 32'(IRRIGATE_MS);
  assign flush_done = elapsed > {10'd0, flush_ms};
  assign dose_ready = since_dose >= pulse_32;
  assign pulse_over = elapsed >= pulse_32;

  // Band tests without signed bounds: below means reading + band < target.
  assign ph_sum  = {1'b0, in_q.ph_reading} + {1'b0, ph_band_q};
  assign ph_hi   = {1'b0, ph_target_q} + {1'b0, ph_band_q};
  assign ph_low  = ph_sum < {1'b0, ph_target_q};
  assign ph_high = {1'b0, in_q.ph_reading} > ph_hi;
  assign ph_in   = !ph_low && !ph_high;

  assign ec_sum  = {1'b0, in_q.ec_reading} + {1'b0, ec_band_q};
  assign ec_hi   = {1'b0, ec_target_q} + {1'b0, ec_band_q};
  assign ec_low  = ec_sum < {1'b0, ec_target_q};
  assign ec_high = {1'b0, in_q.ec_reading} > ec_hi;
  assign ec_in   = !ec_low && !ec_high;

  // ---------------------------------------------------------------------------
  // Next state: phase, start time, dose pulse bookkeeping.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    last_dose_d = last_dose_q;
    dose_d      = dose_q;
    pump_sel_d  = pump_sel_q;
    if (manual_write) begin
      // Manual hold: park at idle and drop any pulse in flight.
      phase_d = fds_pkg::PH_IDLE;
      dose_d  = 1'b0;
    end else if (run_tick) begin
      phase_d = cur_phase;
      start_d = start_eff;
      unique case (cur_phase)
        fds_pkg::PH_IDLE: begin
          phase_d = fds_pkg::PH_FILL;
          start_d = in_q.now_ms;
        end
        fds_pkg::PH_FILL: begin
          if (fill_limit || fill_done) begin
            phase_d = fds_pkg::PH_PHDOSE;
            start_d = in_q.now_ms;
          end
        end
        fds_pkg::PH_PHDOSE, fds_pkg::PH_ECDOSE: begin
          priority if ((cur_phase == fds_pkg::PH_PHDOSE) ? ph_in : ec_in) begin
            dose_d  = 1'b0;
            phase_d = (cur_phase == fds_pkg::PH_PHDOSE) ? fds_pkg::PH_ECDOSE
                                                         : fds_pkg::PH_IRR;
            start_d = in_q.now_ms;
          end else if ((cur_phase == fds_pkg::PH_PHDOSE) ? ph_low : ec_low) begin
            if (!dose_q) begin
              // Start a pulse once the hold-off since the last one has run out.
              if (dose_ready) begin
                dose_d     = 1'b1;
                pump_sel_d = (cur_phase == fds_pkg::PH_ECDOSE);
                start_d    = in_q.now_ms;
              end
            end else if (pulse_over) begin
              dose_d      = 1'b0;
              last_dose_d = in_q.now_ms;
            end
          end else begin
            // Too high: nothing can lower it, so move on and leave the pumps.
            phase_d = (cur_phase == fds_pkg::PH_PHDOSE) ? fds_pkg::PH_ECDOSE
                                                         : fds_pkg::PH_IRR;
            start_d = in_q.now_ms;
          end
        end
        fds_pkg::PH_IRR: begin
          if (irr_done) begin
            phase_d = fds_pkg::PH_FLUSH;
            start_d = in_q.now_ms;
          end
        end
        fds_pkg::PH_FLUSH: begin
          if (flush_done) begin
            phase_d = fds_pkg::PH_IDLE;
            start_d = in_q.now_ms;
          end
        end
        fds_pkg::PH_ERROR: ;
        default: begin
          // Unused code: hold everything.
          phase_d = phase_q;
          start_d = start_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Relay outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    relays_d = relays_q;
    if (run_tick) begin
      unique case (cur_phase)
        fds_pkg::PH_IDLE: begin
          relays_d                         = '0;
          relays_d[fds_pkg::RLY_WATER]   = 1'b1;
          relays_d[fds_pkg::RLY_STIRRER] = 1'b1;
        end
        fds_pkg::PH_FILL: begin
          relays_d[fds_pkg::RLY_WATER] = 1'b1;
          if (fill_limit) begin
            relays_d[fds_pkg::RLY_WATER]   = 1'b0;
            relays_d[fds_pkg::RLY_STIRRER] = 1'b0;
          end else if (fill_done) begin
            relays_d[fds_pkg::RLY_WATER] = 1'b0;
          end
        end
        fds_pkg::PH_PHDOSE, fds_pkg::PH_ECDOSE: begin
          priority if ((cur_phase == fds_pkg::PH_PHDOSE) ? ph_in : ec_in) begin
            if (cur_phase == fds_pkg::PH_PHDOSE) begin
              relays_d[fds_pkg::RLY_BASE] = 1'b0;
            end else begin
              relays_d[fds_pkg::RLY_FERT] = 1'b0;
            end
          end else if ((cur_phase == fds_pkg::PH_PHDOSE) ? ph_low : ec_low) begin
            if (!dose_q) begin
              if (dose_ready) begin
                if (cur_phase == fds_pkg::PH_PHDOSE) begin
                  relays_d[fds_pkg::RLY_BASE] = 1'b1;
                end else begin
                  relays_d[fds_pkg::RLY_FERT] = 1'b1;
                end
              end
            end else if (pulse_over) begin
              // End the pending pulse on whichever pump started it.
              if (pump_sel_q) begin
                relays_d[fds_pkg::RLY_FERT] = 1'b0;
              end else begin
                relays_d[fds_pkg::RLY_BASE] = 1'b0;
              end
            end
          end else begin
            relays_d = relays_q;
          end
        end
        fds_pkg::PH_IRR: begin
          relays_d[fds_pkg::RLY_WATER] = 1'b1;
          relays_d[fds_pkg::RLY_FERT]  = 1'b0;
          relays_d[fds_pkg::RLY_BASE]  = 1'b0;
          if (irr_done) begin
            relays_d[fds_pkg::RLY_WATER] = 1'b0;
            relays_d[fds_pkg::RLY_FLUSH] = 1'b1;
          end
        end
        fds_pkg::PH_FLUSH: begin
          relays_d = '0;
          if (!flush_done) begin
            relays_d[fds_pkg::RLY_FLUSH] = 1'b1;
            relays_d[fds_pkg::RLY_WATER] = 1'b1;
          end
        end
        fds_pkg::PH_ERROR: begin
          relays_d                     = '0;
          relays_d[fds_pkg::RLY_ALARM] = 1'b1;
        end
        default: relays_d = relays_q;
      endcase
    end
  end

  always_comb begin
    out_d.water_on   = relays_d[fds_pkg::RLY_WATER];
    out_d.stirrer_on = relays_d[fds_pkg::RLY_STIRRER];
    out_d.base_on    = relays_d[fds_pkg::RLY_BASE];
    out_d.fert_on    = relays_d[fds_pkg::RLY_FERT];
    out_d.flush_on   = relays_d[fds_pkg::RLY_FLUSH];
    out_d.alarm_on   = relays_d[fds_pkg::RLY_ALARM];
    out_d.cur_phase  = phase_d;
    out_d.dosing     = dose_d;
  end

  // ---------------------------------------------------------------------------
  // State and result registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fds_pkg::PH_IDLE;
      start_q     <= '0;
      last_dose_q <= '0;
      dose_q      <= 1'b0;
      pump_sel_q  <= 1'b0;
      relays_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      start_q     <= start_d;
      last_dose_q <= last_dose_d;
      dose_q      <= dose_d;
      pump_sel_q  <= pump_sel_d;
      relays_q    <= relays_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `include "fertigation_dose_sequencer_unit_macros.svh"

  `FDS_ASSERT_NEXT(a_in_hold, in_valid_q && !fire, in_valid_q)
  `FDS_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_q)
  `FDS_ASSERT_NEXT(a_state_quiet, !fire && !cfg_we_i, $stable(phase_q) && $stable(dose_q) && $stable(relays_q))
  `FDS_ASSERT_NEXT(a_manual_parks, manual_write, (phase_q == fds_pkg::PH_IDLE) && !dose_q)
  `FDS_ASSERT_NEXT(a_error_trip, run_tick && err_trip, (phase_q == fds_pkg::PH_ERROR) && (relays_q == 6'b100000))

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the fertigation dose sequencer: directed and random ticks.
module tb_top;

  // Build parameters of the block under test; the predictor uses the same values.
  localparam int unsigned FILL_LIMIT_MS = 30000;
  localparam int unsigned FILL_DONE_MS  = 15000;
  localparam int unsigned IRRIGATE_MS   = 60000;
  localparam bit          SIM_BUILD     = 1'b0;

  // Field ranges of readings and registers.
  localparam int unsigned PH_MAX        = 1400;
  localparam int unsigned EC_MAX        = 10000;
  localparam int unsigned FLUSH_S_MAX   = 3600;
  localparam int unsigned PULSE_MS_MAX  = 600000;
  localparam int unsigned MS_IN_SECOND  = 1000;

  // Register index that the block has no register behind.
  localparam logic [2:0]  CFG_IDX_SPARE = 3'd7;

  // Allow a little slack after the last result before touching registers.
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          RX_HOLD_CYCLES = 200;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_ROUNDS  = 12;
  localparam int          ROUND_ITEMS    = 30;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  fds_pkg::fds_in_t               in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  fds_pkg::fds_out_t              out_data_o;
  logic                           cfg_we_i;
  logic [2:0]                     cfg_idx_i;
  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data_i;

  always #2 clk_i = ~clk_i;

  fertigation_dose_sequencer_unit #(
    .FILL_LIMIT_MS(FILL_LIMIT_MS),
    .FILL_DONE_MS (FILL_DONE_MS),
    .IRRIGATE_MS  (IRRIGATE_MS),
    .SIM_BUILD    (SIM_BUILD)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Sequencer predictor: shadow registers and a copy of the sequencer state.
  // ---------------------------------------------------------------------------
  logic        c_manual;
  logic [10:0] c_ph_target;
  logic [10:0] c_ph_band;
  logic [13:0] c_ec_target;
  logic [13:0] c_ec_band;
  logic [11:0] c_flush_s;
  logic [19:0] c_pulse_ms;

  fds_pkg::fds_phase_e m_phase;
  logic [31:0]         m_phase_t0;
  logic [31:0]         m_dose_end_t;
  logic                m_dose_on;
  logic                m_fert_sel;
  logic [5:0]          m_relays;

  // Relay and phase state expected per accepted tick, oldest first.
  fds_pkg::fds_out_t relay_expect_q[$];
  fds_pkg::fds_out_t oldest_tick_result;

  // Stimulus and bookkeeping.
  logic [31:0] clock_ms;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_rx_req;
  int          fail_count;
  int          quiet_cycles;

  function automatic void reset_model();
    c_manual     = fds_pkg::RST_RUN_MODE;
    c_ph_target  = fds_pkg::RST_PH_TARGET;
    c_ph_band    = fds_pkg::RST_PH_BAND;
    c_ec_target  = fds_pkg::RST_EC_TARGET;
    c_ec_band    = fds_pkg::RST_EC_BAND;
    c_flush_s    = fds_pkg::RST_FLUSH_S;
    c_pulse_ms   = fds_pkg::RST_PULSE_MS;
    m_phase      = fds_pkg::PH_IDLE;
    m_phase_t0   = '0;
    m_dose_end_t = '0;
    m_dose_on    = 1'b0;
    m_fert_sel   = 1'b0;
    m_relays     = '0;
  endfunction

  // Elapsed milliseconds; wraps modulo 2^32 like the block's time base.
  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] t0);
    return now - t0;
  endfunction

  function automatic void enter_phase(input fds_pkg::fds_phase_e ph, input logic [31:0] now);
    m_phase    = ph;
    m_phase_t0 = now;
  endfunction

  // Start a pulse once the hold-off has passed, or end the running one once it
  // has lasted a full pulse. A running pulse is ended on the pump it started on.
  function automatic void pump_pulse(input logic fert, input fds_pkg::fds_phase_e ph,
                                     input logic [31:0] now);
    if (!m_dose_on) begin
      if (since(now, m_dose_end_t) < 32'(c_pulse_ms)) return;
      m_dose_on  = 1'b1;
      m_fert_sel = fert;
      m_relays[fert ? fds_pkg::RLY_FERT : fds_pkg::RLY_BASE] = 1'b1;
      enter_phase(ph, now);
    end else if (since(now, m_phase_t0) >= 32'(c_pulse_ms)) begin
      m_relays[m_fert_sel ? fds_pkg::RLY_FERT : fds_pkg::RLY_BASE] = 1'b0;
      m_dose_on    = 1'b0;
      m_dose_end_t = now;
    end
  endfunction

  function automatic void shadow_cfg(input logic [2:0] idx, input logic [19:0] d);
    case (idx)
      fds_pkg::CFG_RUN_MODE: begin
        c_manual = d[0];
        // Entering manual hold parks the sequencer at idle and drops the pulse.
        if (d[0]) begin
          m_phase   = fds_pkg::PH_IDLE;
          m_dose_on = 1'b0;
        end
      end
      fds_pkg::CFG_PH_TARGET:     c_ph_target = d[10:0];
      fds_pkg::CFG_PH_BAND:       c_ph_band   = d[10:0];
      fds_pkg::CFG_EC_TARGET:     c_ec_target = d[13:0];
      fds_pkg::CFG_EC_BAND:       c_ec_band   = d[13:0];
      fds_pkg::CFG_FLUSH_SECONDS: c_flush_s   = d[11:0];
      fds_pkg::CFG_DOSE_PULSE_MS: c_pulse_ms  = d;
      default: ;
    endcase
  endfunction

  // Advance the shadow sequencer by one tick and return the relay state it ends in.
  function automatic fds_pkg::fds_out_t predict_tick(input fds_pkg::fds_in_t t);
    int                ph_v, ec_v, ph_lo, ph_hi, ec_lo, ec_hi;
    logic [31:0]       now;
    fds_pkg::fds_out_t r;
    now   = t.now_ms;
    ph_v  = int'(t.ph_reading);
    ec_v  = int'(t.ec_reading);
    // Bounds are signed: target minus band may go below zero.
    ph_lo = int'(c_ph_target) - int'(c_ph_band);
    ph_hi = int'(c_ph_target) + int'(c_ph_band);
    ec_lo = int'(c_ec_target) - int'(c_ec_band);
    ec_hi = int'(c_ec_target) + int'(c_ec_band);
    if (!c_manual) begin
      // A bad sensor flag locks the sequencer in error; the start time is kept
      // if it is already there.
      if ((!t.ph_ok || !t.ec_ok) && !SIM_BUILD && m_phase != fds_pkg::PH_ERROR)
        enter_phase(fds_pkg::PH_ERROR, now);
      case (m_phase)
        fds_pkg::PH_IDLE: begin
          m_relays = '0;
          enter_phase(fds_pkg::PH_FILL, now);
          m_relays[fds_pkg::RLY_WATER]   = 1'b1;
          m_relays[fds_pkg::RLY_STIRRER] = 1'b1;
        end
        fds_pkg::PH_FILL: begin
          m_relays[fds_pkg::RLY_WATER] = 1'b1;
          // Limit first, then done, each against the start time as it stands.
          if (since(now, m_phase_t0) > FILL_LIMIT_MS) begin
            m_relays[fds_pkg::RLY_WATER]   = 1'b0;
            m_relays[fds_pkg::RLY_STIRRER] = 1'b0;
            enter_phase(fds_pkg::PH_PHDOSE, now);
          end
          if (since(now, m_phase_t0) > FILL_DONE_MS) begin
            m_relays[fds_pkg::RLY_WATER] = 1'b0;
            enter_phase(fds_pkg::PH_PHDOSE, now);
          end
        end
        fds_pkg::PH_PHDOSE: begin
          if (ph_v >= ph_lo && ph_v <= ph_hi) begin
            m_dose_on = 1'b0;
            m_relays[fds_pkg::RLY_BASE] = 1'b0;
            enter_phase(fds_pkg::PH_ECDOSE, now);
          end else if (ph_v < ph_lo) begin
            pump_pulse(1'b0, fds_pkg::PH_PHDOSE, now);
          end else begin
            // No acid pump: move on and leave pumps and pulse as they are.
            enter_phase(fds_pkg::PH_ECDOSE, now);
          end
        end
        fds_pkg::PH_ECDOSE: begin
          if (ec_v >= ec_lo && ec_v <= ec_hi) begin
            m_dose_on = 1'b0;
            m_relays[fds_pkg::RLY_FERT] = 1'b0;
            enter_phase(fds_pkg::PH_IRR, now);
          end else if (ec_v < ec_lo) begin
            pump_pulse(1'b1, fds_pkg::PH_ECDOSE, now);
          end else begin
            enter_phase(fds_pkg::PH_IRR, now);
          end
        end
        fds_pkg::PH_IRR: begin
          m_relays[fds_pkg::RLY_WATER] = 1'b1;
          m_relays[fds_pkg::RLY_FERT]  = 1'b0;
          m_relays[fds_pkg::RLY_BASE]  = 1'b0;
          if (since(now, m_phase_t0) > IRRIGATE_MS) begin
            m_relays[fds_pkg::RLY_WATER] = 1'b0;
            enter_phase(fds_pkg::PH_FLUSH, now);
            m_relays[fds_pkg::RLY_FLUSH] = 1'b1;
          end
        end
        fds_pkg::PH_FLUSH: begin
          m_relays = '0;
          m_relays[fds_pkg::RLY_FLUSH] = 1'b1;
          m_relays[fds_pkg::RLY_WATER] = 1'b1;
          if (since(now, m_phase_t0) > 32'(c_flush_s) * MS_IN_SECOND) begin
            m_relays[fds_pkg::RLY_FLUSH] = 1'b0;
            m_relays[fds_pkg::RLY_WATER] = 1'b0;
            enter_phase(fds_pkg::PH_IDLE, now);
          end
        end
        fds_pkg::PH_ERROR: begin
          m_relays = '0;
          m_relays[fds_pkg::RLY_ALARM] = 1'b1;
        end
        default: ;
      endcase
    end
    r.water_on   = m_relays[fds_pkg::RLY_WATER];
    r.stirrer_on = m_relays[fds_pkg::RLY_STIRRER];
    r.base_on    = m_relays[fds_pkg::RLY_BASE];
    r.fert_on    = m_relays[fds_pkg::RLY_FERT];
    r.flush_on   = m_relays[fds_pkg::RLY_FLUSH];
    r.alarm_on   = m_relays[fds_pkg::RLY_ALARM];
    r.cur_phase  = m_phase;
    r.dosing     = m_dose_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven with nonblocking assignments right after a
  // rising edge, so the block samples stable values at the next one.
  // ---------------------------------------------------------------------------

  // Offer one tick, after a random idle gap, and hold it until the transaction
  // completes. Valid is left high so back-to-back ticks need no second write.
  task automatic send_tick(input fds_pkg::fds_in_t t);
    cfg_we_i <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    relay_expect_q.push_back(predict_tick(t));
  endtask

  task automatic tick(input logic [31:0] step, input logic [10:0] ph,
                      input logic [13:0] ec, input bit pok, input bit eok);
    fds_pkg::fds_in_t t;
    clock_ms     = clock_ms + step;
    t.now_ms     = clock_ms;
    t.ph_reading = ph;
    t.ec_reading = ec;
    t.ph_ok      = pok;
    t.ec_ok      = eok;
    send_tick(t);
  endtask

  // Write one register; the enable is dropped by whatever drives next.
  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    shadow_cfg(idx, d);
    @(posedge clk_i);
  endtask

  // Stop offering, then hold until every outstanding tick has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (relay_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_idling(input int profile);
    case (profile)
      1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
      3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // Readings: half inside the current band, half anywhere in range, so the
  // dosing phases see low, in-band and high values.
  function automatic logic [10:0] rand_ph();
    int lo, hi;
    lo = int'(c_ph_target) - int'(c_ph_band);
    hi = int'(c_ph_target) + int'(c_ph_band);
    if (lo < 0) lo = 0;
    if (hi > int'(PH_MAX)) hi = int'(PH_MAX);
    if ($urandom_range(0, 1)) return 11'($urandom_range(hi, lo));
    return 11'($urandom_range(PH_MAX, 0));
  endfunction

  function automatic logic [13:0] rand_ec();
    int lo, hi;
    lo = int'(c_ec_target) - int'(c_ec_band);
    hi = int'(c_ec_target) + int'(c_ec_band);
    if (lo < 0) lo = 0;
    if (hi > int'(EC_MAX)) hi = int'(EC_MAX);
    if ($urandom_range(0, 1)) return 14'($urandom_range(hi, lo));
    return 14'($urandom_range(EC_MAX, 0));
  endfunction

  // Mostly small time steps so every phase gets visited; now and then a
  // large jump, or one across the 32-bit wrap.
  task automatic rand_tick(input bit allow_fault);
    logic [31:0] step;
    bit          pok, eok;
    case ($urandom_range(0, 19))
      0:       step = $urandom;
      1:       step = $urandom_range(4000000, 0);
      2, 3:    step = $urandom_range(2, 0);
      default: step = $urandom_range(6000, 0);
    endcase
    pok = 1'b1;
    eok = 1'b1;
    if (allow_fault && $urandom_range(0, 79) == 0) begin
      case ($urandom_range(0, 2))
        0:       pok = 1'b0;
        1:       eok = 1'b0;
        default: begin pok = 1'b0; eok = 1'b0; end
      endcase
    end
    tick(step, rand_ph(), rand_ec(), pok, eok);
  endtask

  // mode 0 gives the lowest value, 1 the highest, anything else a random one.
  function automatic int unsigned pick_value(input int mode, input int unsigned hi_v);
    case (mode)
      0:       return 0;
      1:       return hi_v;
      default: return $urandom_range(hi_v, 0);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk a full cycle on reset settings: the fill-done, irrigate and flush timers
  // each on and one past the limit, each band on its edge. Time crosses the wrap.
  task automatic test_reset_cycle();
    set_idling(0);
    tick(0,     650, 1500, 1'b1, 1'b1);  // idle to fill
    tick(15000, 650, 1500, 1'b1, 1'b1);  // fill, exactly on the done time
    tick(1,     650, 1500, 1'b1, 1'b1);  // fill done
    tick(10,    600, 1500, 1'b1, 1'b1);  // pH on the low edge: in band
    tick(10,    650, 1700, 1'b1, 1'b1);  // EC on the high edge: in band
    tick(60000, 650, 1500, 1'b1, 1'b1);  // irrigate, exactly on its time
    tick(1,     650, 1500, 1'b1, 1'b1);  // to flush
    tick(30000, 650, 1500, 1'b1, 1'b1);  // flush, exactly on its time
    tick(1,     650, 1500, 1'b1, 1'b1);  // back to idle
    wait_drained();
  endtask

  // Short pulses: hold-off, pulse end, pH too high with a pulse running,
  // the running base pulse finished in EC dose, then a fertiliser pulse.
  task automatic test_dose_pulses();
    set_idling(0);
    cfg_write(fds_pkg::CFG_DOSE_PULSE_MS, 20'd100);
    tick(0,     650,  1500, 1'b1, 1'b1);  // idle to fill
    tick(30001, 650,  1500, 1'b1, 1'b1);  // fill limit and done in one tick
    tick(1,     0,    1500, 1'b1, 1'b1);  // base pulse starts
    tick(50,    0,    1500, 1'b1, 1'b1);  // pulse still short
    tick(50,    0,    1500, 1'b1, 1'b1);  // pulse ends
    tick(99,    0,    1500, 1'b1, 1'b1);  // hold-off not yet over
    tick(1,     0,    1500, 1'b1, 1'b1);  // second base pulse
    tick(1,     11'(PH_MAX), 1500, 1'b1, 1'b1);  // pH high: skip to EC, pulse kept
    tick(100,   650,  0,    1'b1, 1'b1);  // finish the base pulse from EC dose
    tick(100,   650,  0,    1'b1, 1'b1);  // fertiliser pulse
    tick(5,     650,  14'(EC_MAX), 1'b1, 1'b1);  // EC high: on to irrigate
    tick(1,     650,  1500, 1'b1, 1'b1);  // irrigate clears the pumps
    wait_drained();
  endtask

  // Sensor faults lock in error; manual hold frees it and freezes the relays.
  task automatic test_sensor_faults();
    set_idling(0);
    tick(3, 650, 1500, 1'b1, 1'b0);       // EC flag low: error, alarm
    tick(3, 650, 1500, 1'b1, 1'b1);       // good readings: still error
    wait_drained();
    cfg_write(fds_pkg::CFG_RUN_MODE, 20'd1);
    tick(3, 0, 0, 1'b0, 1'b0);            // manual: nothing moves
    wait_drained();
    cfg_write(CFG_IDX_SPARE, 20'hFFFFF);  // no register here: ignore
    cfg_write(fds_pkg::CFG_RUN_MODE, 20'd0);
    tick(3, 650, 1500, 1'b1, 1'b1);       // idle to fill
    tick(3, 650, 1500, 1'b0, 1'b1);       // pH flag low in fill
    wait_drained();
    cfg_write(fds_pkg::CFG_RUN_MODE, 20'd1);
    cfg_write(fds_pkg::CFG_RUN_MODE, 20'd0);
    wait_drained();
  endtask

  // Hold the result side off for a long stretch while ticks keep coming, so
  // the block fills and stalls its input; then pause until it has emptied.
  task automatic test_backpressure();
    set_idling(0);
    hold_rx_req = 1'b1;
    repeat (24) rand_tick(1'b0);
    wait_drained();
    repeat (8) rand_tick(1'b0);
    wait_drained();
  endtask

  // Rounds of random ticks, each on fresh settings and a fresh idling mix.
  // The first round uses every register's lowest value, the second its highest.
  task automatic test_random_rounds();
    int mode;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      wait_drained();
      set_idling(round % 4);
      // Free a locked error, and now and then tick a few times in manual hold.
      if (m_phase == fds_pkg::PH_ERROR || round % 5 == 4) begin
        cfg_write(fds_pkg::CFG_RUN_MODE, 20'd1);
        if (round % 5 == 4) begin
          repeat (3) rand_tick(1'b1);
          wait_drained();
        end
        cfg_write(fds_pkg::CFG_RUN_MODE, 20'd0);
      end
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_PH_TARGET, 20'(pick_value(mode, PH_MAX)));
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_PH_BAND, 20'(pick_value(mode, PH_MAX)));
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_EC_TARGET, 20'(pick_value(mode, EC_MAX)));
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_EC_BAND, 20'(pick_value(mode, EC_MAX)));
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_FLUSH_SECONDS, 20'(pick_value(mode, FLUSH_S_MAX)));
      // Keep pulses short on most rounds so dosing completes often.
      mode = (round < 2) ? round : int'($urandom_range(0, 3));
      cfg_write(fds_pkg::CFG_DOSE_PULSE_MS,
                (mode > 1) ? 20'($urandom_range(5000, 0))
                           : 20'(pick_value(mode, PULSE_MS_MAX)));
      if (round % 3 == 2) cfg_write(CFG_IDX_SPARE, 20'($urandom));
      repeat (ROUND_ITEMS) rand_tick(1'b1);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every completed result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (relay_expect_q.size() == 0) begin
        $error("result with no tick outstanding: %h", out_data_o);
        fail_count++;
      end else begin
        oldest_tick_result = relay_expect_q.pop_front();
        check_field("water_on",   32'(oldest_tick_result.water_on),
                    32'(out_data_o.water_on));
        check_field("stirrer_on", 32'(oldest_tick_result.stirrer_on),
                    32'(out_data_o.stirrer_on));
        check_field("base_on",    32'(oldest_tick_result.base_on),
                    32'(out_data_o.base_on));
        check_field("fert_on",    32'(oldest_tick_result.fert_on),
                    32'(out_data_o.fert_on));
        check_field("flush_on",   32'(oldest_tick_result.flush_on),
                    32'(out_data_o.flush_on));
        check_field("alarm_on",   32'(oldest_tick_result.alarm_on),
                    32'(out_data_o.alarm_on));
        check_field("cur_phase",  32'(oldest_tick_result.cur_phase),
                    32'(out_data_o.cur_phase));
        check_field("dosing",     32'(oldest_tick_result.dosing),
                    32'(out_data_o.dosing));
      end
    end
  end

  // Watchdog: end the run if no transaction completes on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    quiet_cycles = 0;
    fail_count   = 0;
    hold_rx_req  = 1'b0;
    // Start just short of the wrap so the first cycle crosses it.
    clock_ms     = 32'hFFFF_C000;
    set_idling(0);
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_cycle();
    test_dose_pulses();
    test_sensor_faults();
    test_backpressure();
    test_random_rounds();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && relay_expect_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ===== fertigation_dose_sequencer_unit.f =====
+incdir+rtl
rtl/fds_pkg.sv
rtl/fertigation_dose_sequencer_unit.sv
dv/tb_top.sv
